### hdl/eau_pkg.sv
package eau_pkg;

	localparam int POLY_DEGREE_DEF = 9;
	localparam int FRAC_BITS_DEF   = 16;

	localparam int LAMBDA_W = 17;
	localparam int PHI_W    = 32;
	localparam int OUT_W    = 32;

	// 1.0 in Q1.16
	localparam logic [LAMBDA_W-1:0] LAMBDA_ONE = 17'h10000;

	localparam int EXPTAB_COUNT = 18;

	// e^-0.5 / n!, scaled by 2^32
	function automatic logic [31:0] coef_q32(input int idx);
		logic [31:0] c;
		case (idx)
			0:       c = 32'd2605029347;
			1:       c = 32'd2605029347;
			2:       c = 32'd1302514673;
			3:       c = 32'd434171558;
			4:       c = 32'd108542889;
			5:       c = 32'd21708578;
			6:       c = 32'd3618096;
			7:       c = 32'd516871;
			8:       c = 32'd64609;
			9:       c = 32'd7179;
			10:      c = 32'd718;
			11:      c = 32'd65;
			12:      c = 32'd5;
			default: c = 32'd0;
		endcase
		return c;
	endfunction

	// e^-k, scaled by 2^24
	function automatic logic [24:0] exptab_q24(input logic [4:0] idx);
		logic [24:0] e;
		case (idx)
			5'd0:    e = 25'd16777216;
			5'd1:    e = 25'd6171993;
			5'd2:    e = 25'd2270549;
			5'd3:    e = 25'd835288;
			5'd4:    e = 25'd307285;
			5'd5:    e = 25'd113044;
			5'd6:    e = 25'd41587;
			5'd7:    e = 25'd15299;
			5'd8:    e = 25'd5628;
			5'd9:    e = 25'd2070;
			5'd10:   e = 25'd762;
			5'd11:   e = 25'd280;
			5'd12:   e = 25'd103;
			5'd13:   e = 25'd38;
			5'd14:   e = 25'd14;
			5'd15:   e = 25'd5;
			5'd16:   e = 25'd2;
			5'd17:   e = 25'd1;
			default: e = 25'd0;
		endcase
		return e;
	endfunction

endpackage

### hdl/eau_cell.sv
module eau_cell #(
	parameter int FRAC_BITS = eau_pkg::FRAC_BITS_DEF,
	parameter int COEF_IDX  = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [FRAC_BITS+2:0]     acc_in,
	input  logic signed [FRAC_BITS:0]       y_in,
	input  logic        [FRAC_BITS:0]       ek_in,
	input  logic        [eau_pkg::PHI_W-1:0] phi_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [FRAC_BITS+2:0]     acc,
	output logic signed [FRAC_BITS:0]       y,
	output logic        [FRAC_BITS:0]       ek,
	output logic        [eau_pkg::PHI_W-1:0] phi
);

	localparam int AW = FRAC_BITS + 3;
	localparam int YW = FRAC_BITS + 1;
	localparam int PW = AW + YW;
	localparam logic [AW-1:0] COEF = AW'(eau_pkg::coef_q32(COEF_IDX) >> (32 - FRAC_BITS));

	logic              valid_q;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_sh;
	logic [AW-1:0]     acc_nxt;

	// one horner step: floor(acc * y / 2^F) + coefficient
	assign prod    = acc_in * y_in;
	assign prod_sh = prod >>> FRAC_BITS;
	assign acc_nxt = prod_sh[AW-1:0] + COEF;

	assign in_ready  = ~valid_q | out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			acc <= acc_nxt;
			y   <= y_in;
			ek  <= ek_in;
			phi <= phi_in;
		end
	end

endmodule

### hdl/exponential_adaptation_unit_top.sv
// Exponential adaptation unit: adapted = phi * exp(-lambda * phi), Q16.16 in and out.
// Request channel phi_valid / phi_ready carries phi; result channel adapted_valid /
// adapted_ready carries adapted. lambda (Q1.16, values above 1.0 act as 1.0) is written
// with lambda_wen, which the user must do only while the block is idle; the block does not
// enforce this. lambda resets to zero. One request is taken per cycle while phi_ready is
// high. The data path is a pipeline of POLY_DEGREE + 4 registered stages: rate multiply,
// range split and e^-k lookup, one horner cell per polynomial degree, the e^-k scaling
// multiply and the final phi multiply with saturation. A new request can enter before
// earlier ones are through; one result leaves per cycle while adapted_ready is high.
// Each stage has its own valid bit and moves whenever the stage after it is empty or
// moving, so when the receiver stalls the results back up stage by stage and requests
// are still taken until every stage is full; nothing is dropped.
// Reset clears all valid bits and lambda; no request is in flight after reset.
module exponential_adaptation_unit_top #(
	parameter int POLY_DEGREE = eau_pkg::POLY_DEGREE_DEF,
	parameter int FRAC_BITS   = eau_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            lambda_wen,
	input  logic [eau_pkg::LAMBDA_W-1:0]    lambda,
	input  logic                            phi_valid,
	output logic                            phi_ready,
	input  logic [eau_pkg::PHI_W-1:0]       phi,
	output logic                            adapted_valid,
	input  logic                            adapted_ready,
	output logic [eau_pkg::OUT_W-1:0]       adapted
);

	localparam int PHI_W = eau_pkg::PHI_W;
	localparam int TW    = 48;
	localparam int AW    = FRAC_BITS + 3;
	localparam int YW    = FRAC_BITS + 1;
	localparam int EKW   = FRAC_BITS + 1;
	localparam int EW    = FRAC_BITS + 3;
	localparam int RW    = PHI_W + EW;
	localparam logic [YW-1:0]  HALF  = YW'(1) << (FRAC_BITS - 1);
	localparam logic [EKW-1:0] ONE_F = EKW'(1) << FRAC_BITS;
	localparam logic [AW-1:0]  ACC0  =
		AW'(eau_pkg::coef_q32(POLY_DEGREE) >> (32 - FRAC_BITS));

	logic [eau_pkg::LAMBDA_W-1:0] lambda_q;
	logic [eau_pkg::LAMBDA_W-1:0] lam_c;

	// stage 1: t = lambda * phi
	logic                 v_s1, rdy_s1;
	logic [TW:0]          t_full;
	logic [TW-1:0]        t_s1;
	logic [PHI_W-1:0]     phi_s1;

	// stage 2: split t, form y and e^-k
	logic                 v_s2, rdy_s2;
	logic                 t_small;
	logic [15:0]          k;
	logic [32:0]          f_full;
	logic [YW-1:0]        f;
	logic [24:0]          ek_full;
	logic signed [YW-1:0] y_s2;
	logic [EKW-1:0]       ek_s2;
	logic [PHI_W-1:0]     phi_s2;

	// horner cells
	logic [POLY_DEGREE:0] vld_c, rdy_c;
	logic signed [AW-1:0] acc_c [POLY_DEGREE+1];
	logic signed [YW-1:0] y_c   [POLY_DEGREE+1];
	logic [EKW-1:0]       ek_c  [POLY_DEGREE+1];
	logic [PHI_W-1:0]     phi_c [POLY_DEGREE+1];

	// stage 3: e = e^-k * P
	logic                 v_s3, rdy_s3;
	logic [AW-2:0]        acc_pos;
	logic [EKW+AW-2:0]    e_full;
	logic [EW-1:0]        e_s3;
	logic [PHI_W-1:0]     phi_s3;

	// stage 4: phi * e, saturated
	logic                 v_s4, rdy_s4;
	logic [RW-1:0]        r_full;
	logic [RW-FRAC_BITS-1:0] r;
	logic [eau_pkg::OUT_W-1:0] adapted_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= '0;
		end else if (lambda_wen) begin
			lambda_q <= lambda;
		end
	end

	assign lam_c = (lambda_q > eau_pkg::LAMBDA_ONE) ? eau_pkg::LAMBDA_ONE : lambda_q;

	// ready chain, back to front
	assign rdy_s4    = ~v_s4 | adapted_ready;
	assign rdy_s3    = ~v_s3 | rdy_s4;
	assign rdy_c[POLY_DEGREE] = rdy_s3;
	assign rdy_s2    = ~v_s2 | rdy_c[0];
	assign rdy_s1    = ~v_s1 | rdy_s2;
	assign phi_ready = rdy_s1;

	// stage 1
	assign t_full = (TW+1)'(lam_c) * (TW+1)'(phi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= phi_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && phi_valid) begin
			t_s1   <= t_full[TW-1:0];
			phi_s1 <= phi;
		end
	end

	// stage 2: up to and including 1.0 the whole of t is the fraction
	assign t_small = (t_s1 <= TW'(64'h1_0000_0000));
	assign k       = t_small ? 16'd0 : t_s1[TW-1:32];
	assign f_full  = t_small ? t_s1[32:0] : {1'b0, t_s1[31:0]};
	assign f       = f_full[32:32-FRAC_BITS];
	assign ek_full = (k < 16'(eau_pkg::EXPTAB_COUNT)) ? eau_pkg::exptab_q24(k[4:0]) : 25'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			y_s2   <= HALF - f;
			ek_s2  <= EKW'(ek_full >> (24 - FRAC_BITS));
			phi_s2 <= phi_s1;
		end
	end

	assign vld_c[0] = v_s2;
	assign acc_c[0] = ACC0;
	assign y_c[0]   = y_s2;
	assign ek_c[0]  = ek_s2;
	assign phi_c[0] = phi_s2;

	// cell j applies coefficient POLY_DEGREE-1-j
	for (genvar j = 0; j < POLY_DEGREE; j++) begin : g_cell
		eau_cell #(
			.FRAC_BITS (FRAC_BITS),
			.COEF_IDX  (POLY_DEGREE - 1 - j)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[j]),
			.in_ready  (rdy_c[j]),
			.acc_in    (acc_c[j]),
			.y_in      (y_c[j]),
			.ek_in     (ek_c[j]),
			.phi_in    (phi_c[j]),
			.out_valid (vld_c[j+1]),
			.out_ready (rdy_c[j+1]),
			.acc       (acc_c[j+1]),
			.y         (y_c[j+1]),
			.ek        (ek_c[j+1]),
			.phi       (phi_c[j+1])
		);
	end

	// stage 3: negative polynomial clamps to zero
	assign acc_pos = acc_c[POLY_DEGREE][AW-1] ? '0 : acc_c[POLY_DEGREE][AW-2:0];
	assign e_full  = (EKW+AW-1)'(ek_c[POLY_DEGREE]) * (EKW+AW-1)'(acc_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= vld_c[POLY_DEGREE];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_c[POLY_DEGREE]) begin
			e_s3   <= e_full[EKW+AW-2:FRAC_BITS];
			phi_s3 <= phi_c[POLY_DEGREE];
		end
	end

	// stage 4
	assign r_full = RW'(phi_s3) * RW'(e_s3);
	assign r      = r_full[RW-1:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			adapted_s4 <= (|r[RW-FRAC_BITS-1:eau_pkg::OUT_W]) ? '1 : r[eau_pkg::OUT_W-1:0];
		end
	end

	assign adapted_valid = v_s4;
	assign adapted       = adapted_s4;

	// y stays within [-0.5, 0.5]
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (y_s2 <= $signed(HALF)) && (y_s2 >= -$signed(HALF)))
		else $error("y out of range");

	// table entry never above 1.0
	a_ek_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (ek_s2 <= ONE_F))
		else $error("e^-k above one");

	// a blocked scaling stage keeps its product
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy_s3) |=> (v_s3 && $stable(e_s3) && $stable(phi_s3)))
		else $error("stage 3 lost its data while blocked");

endmodule
